// ===== rtl/i2a_pkg.sv =====
package i2a_pkg;

   localparam int OPCODE_W = 3;
   localparam int VALUE_W  = 64;
   localparam int CHAR_W   = 8;
   localparam int HALF_W   = 32;

   // 20 decimal digits cover any 64-bit magnitude
   localparam int DIGITS   = 20;
   localparam int NIB_W    = 4;
   localparam int BCD_W    = DIGITS * NIB_W;
   localparam int REM_W    = $clog2(DIGITS + 1);
   localparam int BIT_CNT_W = $clog2(VALUE_W);

   localparam logic [OPCODE_W-1:0] OP_SDEC  = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_UDEC  = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_HEXLO = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_HEXUP = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_PTR   = 3'd4;

   localparam logic [CHAR_W-1:0] ASCII_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] ASCII_MINUS   = 8'h2d;
   localparam logic [CHAR_W-1:0] ASCII_X       = 8'h78;
   localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] ASCII_TEN     = 8'd10;

   // Add 3 to every BCD digit of 5 or more, ahead of the next shift
   function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] bcd);
      logic [BCD_W-1:0] res;
      res = bcd;
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd[i*NIB_W +: NIB_W] >= 4'd5) begin
            res[i*NIB_W +: NIB_W] = bcd[i*NIB_W +: NIB_W] + 4'd3;
         end
      end
      return res;
   endfunction

   function automatic logic [CHAR_W-1:0] digit_char(input logic [NIB_W-1:0] d,
                                                    input logic upper);
      logic [CHAR_W-1:0] wide;
      logic [CHAR_W-1:0] res;
      wide = {{(CHAR_W-NIB_W){1'b0}}, d};
      if (d < 4'd10) begin
         res = ASCII_ZERO + wide;
      end else if (upper) begin
         res = ASCII_UPPER_A + wide - ASCII_TEN;
      end else begin
         res = ASCII_LOWER_A + wide - ASCII_TEN;
      end
      return res;
   endfunction

endpackage

// ===== rtl/integer_to_ascii_formatter.sv =====
// Hex and pointer output starts once the leading zeros are dropped, one
// per step; decimal first runs binary-to-BCD shifting over all 64 input
// bits through one shared add-3/shift unit, then drops the leading zeros.
// Characters then leave at one per cycle unless stalled. Throughput: one
// number at a time; the next is accepted at the edge after the last character
// is registered. Synchronous active-high reset returns to idle, drops rsp_valid.
module integer_to_ascii_formatter (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [i2a_pkg::OPCODE_W-1:0]   req_opcode,
   input  logic [i2a_pkg::VALUE_W-1:0]    req_value,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [i2a_pkg::CHAR_W-1:0]     rsp_char_out,
   output logic                           rsp_last
);
   import i2a_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_SKIP = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [VALUE_W-1:0]   mag_ff, mag_in;
   logic [BCD_W-1:0]     digs_ff, digs_in;
   logic [BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [1:0]           pre_ff, pre_in;
   logic                 ptr_ff, ptr_in;
   logic                 upper_ff, upper_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]    rsp_char_ff, rsp_char_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 accept;
   logic                 out_free;
   logic                 neg;
   logic [BCD_W-1:0]     digs_adj;

   assign req_stall    = (state_ff != ST_IDLE);
   assign accept       = req_valid && !req_stall;
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign neg          = req_value[VALUE_W-1];
   assign digs_adj     = bcd_adjust(digs_ff);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_char_out = rsp_char_ff;
   assign rsp_last     = rsp_last_ff;

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      digs_in      = digs_ff;
      bit_cnt_in   = bit_cnt_ff;
      rem_in       = rem_ff;
      pre_in       = pre_ff;
      ptr_in       = ptr_ff;
      upper_in     = upper_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               bit_cnt_in = '0;
               rem_in     = REM_W'(DIGITS);
               ptr_in     = (req_opcode == OP_PTR);
               upper_in   = (req_opcode == OP_HEXUP);
               digs_in    = '0;
               pre_in     = 2'd0;
               priority if (req_opcode == OP_SDEC) begin
                  mag_in   = neg ? (VALUE_W'(0) - req_value) : req_value;
                  pre_in   = neg ? 2'd1 : 2'd0;
                  state_in = ST_CONV;
               end else if (req_opcode == OP_UDEC) begin
                  mag_in   = {{(VALUE_W-HALF_W){1'b0}}, req_value[HALF_W-1:0]};
                  state_in = ST_CONV;
               end else if (req_opcode == OP_HEXLO || req_opcode == OP_HEXUP) begin
                  digs_in  = {{(BCD_W-HALF_W){1'b0}}, req_value[HALF_W-1:0]};
                  state_in = ST_SKIP;
               end else if (req_opcode == OP_PTR) begin
                  digs_in  = {{(BCD_W-VALUE_W){1'b0}}, req_value};
                  pre_in   = 2'd2;
                  state_in = ST_SKIP;
               end else begin
                  // drop unused opcodes
                  state_in = ST_IDLE;
               end
            end
         end
         ST_CONV: begin
            // one double-dabble step: adjust, then shift in the next bit
            digs_in    = {digs_adj[BCD_W-2:0], mag_ff[VALUE_W-1]};
            mag_in     = {mag_ff[VALUE_W-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + 1'b1;
            if (bit_cnt_ff == BIT_CNT_W'(VALUE_W - 1)) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            // drop leading zeros, keep at least one digit
            if (digs_ff[BCD_W-1 -: NIB_W] == '0 && rem_ff > REM_W'(1)) begin
               digs_in = {digs_ff[BCD_W-NIB_W-1:0], {NIB_W{1'b0}}};
               rem_in  = rem_ff - 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (pre_ff != 2'd0) begin
                  if (pre_ff == 2'd2) begin
                     rsp_char_in = ASCII_ZERO;
                  end else begin
                     rsp_char_in = ptr_ff ? ASCII_X : ASCII_MINUS;
                  end
                  rsp_last_in = 1'b0;
                  pre_in      = pre_ff - 1'b1;
               end else begin
                  rsp_char_in = digit_char(digs_ff[BCD_W-1 -: NIB_W], upper_ff);
                  rsp_last_in = (rem_ff == REM_W'(1));
                  digs_in     = {digs_ff[BCD_W-NIB_W-1:0], {NIB_W{1'b0}}};
                  rem_in      = rem_ff - 1'b1;
                  if (rem_ff == REM_W'(1)) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         bit_cnt_ff   <= '0;
         rem_ff       <= '0;
         pre_ff       <= 2'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         bit_cnt_ff   <= bit_cnt_in;
         rem_ff       <= rem_in;
         pre_ff       <= pre_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      digs_ff     <= digs_in;
      ptr_ff      <= ptr_in;
      upper_ff    <= upper_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule
